// ===== src/sssp_pkg.sv =====
// Package for the single-source shortest path core.
// Holds field widths, item kind codes, distance limits and the command and
// status structs shared by the controller and the datapath. No dependencies.
`default_nettype none

package sssp_pkg;

   localparam int MAX_VERTICES_DEF = 16;

   localparam int KIND_W = 2;
   localparam int VTX_W  = 4;
   localparam int WGT_W  = 16;
   localparam int DIST_W = 24;
   localparam int VC_W   = 5;

   localparam logic [KIND_W-1:0] KIND_ADD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_RUN   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd2;

   localparam logic [VC_W-1:0] VERTEX_COUNT_RESET = 5'd16;

   typedef logic signed [WGT_W-1:0]  weight_type;
   typedef logic signed [DIST_W-1:0] dist_type;

   localparam dist_type DIST_MAX = 24'sh7FFFFF;
   localparam dist_type DIST_MIN = 24'sh800000;

   // Commands from the controller. At most one is set per cycle, except that
   // out_last travels with out_load to mark the final result of a run.
   typedef struct packed {
      logic take_item;
      logic mem_clear;
      logic edge_rd;
      logic edge_wr;
      logic run_init;
      logic dist_rd_row;
      logic du_load;
      logic relax_rd;
      logic relax_wr;
      logic out_rd;
      logic out_load;
      logic out_last;
   } dp_cmd_type;

   typedef struct packed {
      logic row_reached;
      logic rsp_busy;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== src/sssp_ctrl.sv =====
// Controller of the shortest path core: state machine, loop counters and the
// vertex count register. Uses sssp_pkg; drives sssp_datapath by commands.
`default_nettype none

module sssp_ctrl #(
   parameter int  MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
   localparam int IDX_W = $clog2(MAX_VERTICES),
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  wire  [sssp_pkg::KIND_W-1:0]      req_kind,
   input  wire                              csr_write_enable,
   input  wire  [sssp_pkg::VC_W-1:0]        csr_write_data,
   output sssp_pkg::dp_cmd_type             cmd,
   input  sssp_pkg::dp_status_type          status,
   output logic [IDX_W-1:0]                 cmd_row,
   output logic [IDX_W-1:0]                 cmd_col,
   output logic [CNT_W-1:0]                 active_count
);
   import sssp_pkg::*;

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_VERTICES - 1);

   typedef enum logic [3:0] {
      S_SWEEP, S_IDLE, S_EDGE_RD, S_EDGE_WR, S_RUN_INIT, S_ROW, S_ROW_LD,
      S_RELAX_RD, S_RELAX_WR, S_OUT_RD, S_OUT_LD
   } state_type;

   state_type         state_ff;
   logic [IDX_W-1:0]  row_ff;
   logic [IDX_W-1:0]  col_ff;
   logic [CNT_W-1:0]  pass_ff;
   logic [VC_W-1:0]   vcount_ff;
   logic [IDX_W-1:0]  last_idx;
   logic              row_last;
   logic              col_last;
   logic              pass_last;

   // A count of zero acts as one, and a count above the store acts as full.
   always_comb begin
      if (vcount_ff == '0) begin
         active_count = CNT_W'(1);
      end else if (32'(vcount_ff) > 32'(MAX_VERTICES)) begin
         active_count = CNT_W'(MAX_VERTICES);
      end else begin
         active_count = CNT_W'(vcount_ff);
      end
   end

   assign last_idx  = IDX_W'(active_count - CNT_W'(1));
   assign row_last  = (row_ff == last_idx);
   assign col_last  = (col_ff == last_idx);
   assign pass_last = ((pass_ff + CNT_W'(2)) == active_count);
   assign req_ready = (state_ff == S_IDLE);
   assign cmd_row   = row_ff;
   assign cmd_col   = col_ff;

   always_comb begin
      cmd = '0;
      case (state_ff)
         S_SWEEP:    cmd.mem_clear   = 1'b1;
         S_IDLE:     cmd.take_item   = req_valid;
         S_EDGE_RD:  cmd.edge_rd     = 1'b1;
         S_EDGE_WR:  cmd.edge_wr     = 1'b1;
         S_RUN_INIT: cmd.run_init    = 1'b1;
         S_ROW:      cmd.dist_rd_row = status.row_reached;
         S_ROW_LD:   cmd.du_load     = 1'b1;
         S_RELAX_RD: cmd.relax_rd    = 1'b1;
         S_RELAX_WR: cmd.relax_wr    = 1'b1;
         S_OUT_RD:   cmd.out_rd      = 1'b1;
         S_OUT_LD: begin
            cmd.out_load = !status.rsp_busy;
            cmd.out_last = col_last;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_SWEEP;
         row_ff    <= '0;
         col_ff    <= '0;
         pass_ff   <= '0;
         vcount_ff <= VERTEX_COUNT_RESET;
      end else begin
         if (csr_write_enable) begin
            vcount_ff <= csr_write_data;
         end
         case (state_ff)
            S_SWEEP: begin
               if (col_ff == IDX_LAST) begin
                  col_ff <= '0;
                  if (row_ff == IDX_LAST) begin
                     row_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     row_ff <= row_ff + IDX_W'(1);
                  end
               end else begin
                  col_ff <= col_ff + IDX_W'(1);
               end
            end
            S_IDLE: begin
               if (req_valid) begin
                  case (req_kind)
                     KIND_ADD:   state_ff <= S_EDGE_RD;
                     KIND_RUN:   state_ff <= S_RUN_INIT;
                     KIND_CLEAR: begin
                        row_ff   <= '0;
                        col_ff   <= '0;
                        state_ff <= S_SWEEP;
                     end
                     default:    state_ff <= S_IDLE;
                  endcase
               end
            end
            S_EDGE_RD: state_ff <= S_EDGE_WR;
            S_EDGE_WR: state_ff <= S_IDLE;
            S_RUN_INIT: begin
               pass_ff <= '0;
               row_ff  <= '0;
               col_ff  <= '0;
               if (active_count == CNT_W'(1)) begin
                  state_ff <= S_OUT_RD;
               end else begin
                  state_ff <= S_ROW;
               end
            end
            S_ROW: begin
               if (status.row_reached) begin
                  state_ff <= S_ROW_LD;
               end else if (row_last) begin
                  row_ff <= '0;
                  if (pass_last) begin
                     col_ff   <= '0;
                     state_ff <= S_OUT_RD;
                  end else begin
                     pass_ff  <= pass_ff + CNT_W'(1);
                     state_ff <= S_ROW;
                  end
               end else begin
                  row_ff   <= row_ff + IDX_W'(1);
                  state_ff <= S_ROW;
               end
            end
            S_ROW_LD: begin
               col_ff   <= '0;
               state_ff <= S_RELAX_RD;
            end
            S_RELAX_RD: state_ff <= S_RELAX_WR;
            S_RELAX_WR: begin
               if (!col_last) begin
                  col_ff   <= col_ff + IDX_W'(1);
                  state_ff <= S_RELAX_RD;
               end else begin
                  col_ff <= '0;
                  if (row_last) begin
                     row_ff <= '0;
                     if (pass_last) begin
                        state_ff <= S_OUT_RD;
                     end else begin
                        pass_ff  <= pass_ff + CNT_W'(1);
                        state_ff <= S_ROW;
                     end
                  end else begin
                     row_ff   <= row_ff + IDX_W'(1);
                     state_ff <= S_ROW;
                  end
               end
            end
            S_OUT_RD: state_ff <= S_OUT_LD;
            S_OUT_LD: begin
               if (!status.rsp_busy) begin
                  if (col_last) begin
                     col_ff   <= '0;
                     state_ff <= S_IDLE;
                  end else begin
                     col_ff   <= col_ff + IDX_W'(1);
                     state_ff <= S_OUT_RD;
                  end
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   // The final result of a run hands control straight back to the idle state.
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load && cmd.out_last |=> req_ready)
      else $error("controller did not return to idle after the last result");

   // Items are taken only in the idle state.
   a_take_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.take_item |-> req_ready && req_valid)
      else $error("item taken outside the idle state");

endmodule

`default_nettype wire

// ===== src/sssp_datapath.sv =====
// Datapath of the shortest path core: edge store, distance store, reach flags,
// relaxation arithmetic and the result register. Uses sssp_pkg; run by sssp_ctrl.
`default_nettype none

module sssp_datapath #(
   parameter int  MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF,
   localparam int IDX_W = $clog2(MAX_VERTICES),
   localparam int CNT_W = $clog2(MAX_VERTICES + 1)
) (
   input  wire                               clock,
   input  wire                               reset,
   input  sssp_pkg::dp_cmd_type              cmd,
   output sssp_pkg::dp_status_type           status,
   input  wire  [IDX_W-1:0]                  cmd_row,
   input  wire  [IDX_W-1:0]                  cmd_col,
   input  wire  [CNT_W-1:0]                  active_count,
   input  wire  [sssp_pkg::VTX_W-1:0]        req_edge_source,
   input  wire  [sssp_pkg::VTX_W-1:0]        req_edge_target,
   input  wire  signed [sssp_pkg::WGT_W-1:0] req_edge_weight,
   input  wire  [sssp_pkg::VTX_W-1:0]        req_start_vertex,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [sssp_pkg::VTX_W-1:0]        rsp_vertex,
   output logic signed [sssp_pkg::DIST_W-1:0] rsp_distance,
   output logic                              rsp_reachable,
   output logic [sssp_pkg::VTX_W-1:0]        rsp_predecessor,
   output logic                              rsp_has_predecessor,
   output logic                              rsp_last
);
   import sssp_pkg::*;

   localparam int ADDR_W     = 2 * IDX_W;
   localparam int EDGE_DEPTH = 1 << ADDR_W;
   localparam int DIST_DEPTH = 1 << IDX_W;
   localparam int EDGE_DW    = WGT_W + 1;
   localparam int DIST_DW    = IDX_W + DIST_W;

   // Edge store word: {present, weight}. Distance store word: {pred, distance}.
   logic [EDGE_DW-1:0]  edge_mem [EDGE_DEPTH];
   logic [DIST_DW-1:0]  dist_mem [DIST_DEPTH];

   logic [VTX_W-1:0]    item_source_ff;
   logic [VTX_W-1:0]    item_target_ff;
   weight_type          item_weight_ff;
   logic [VTX_W-1:0]    item_start_ff;

   logic [EDGE_DW-1:0]  edge_rdata_ff;
   logic [DIST_DW-1:0]  dist_rdata_ff;
   dist_type            du_ff;
   logic [MAX_VERTICES-1:0] reached_ff;
   logic [MAX_VERTICES-1:0] pvalid_ff;

   logic                rsp_valid_ff;
   logic [VTX_W-1:0]    rsp_vertex_ff;
   dist_type            rsp_distance_ff;
   logic                rsp_reachable_ff;
   logic [VTX_W-1:0]    rsp_predecessor_ff;
   logic                rsp_has_pred_ff;
   logic                rsp_last_ff;

   logic [ADDR_W-1:0]   item_addr;
   logic                item_in_range;
   logic                start_ok;
   logic [IDX_W-1:0]    start_idx;
   logic                edge_present;
   weight_type          edge_weight;
   dist_type            dist_v;
   logic [IDX_W-1:0]    pred_v;
   logic signed [DIST_W:0] sum_w;
   dist_type            cand;
   logic                relax_update;
   logic                edge_update;

   logic                edge_we;
   logic [ADDR_W-1:0]   edge_waddr;
   logic [EDGE_DW-1:0]  edge_wdata;
   logic                edge_re;
   logic [ADDR_W-1:0]   edge_raddr;
   logic                dist_we;
   logic [IDX_W-1:0]    dist_waddr;
   logic [DIST_DW-1:0]  dist_wdata;
   logic                dist_re;
   logic [IDX_W-1:0]    dist_raddr;

   assign item_addr     = {IDX_W'(item_source_ff), IDX_W'(item_target_ff)};
   assign item_in_range = (32'(item_source_ff) < 32'(MAX_VERTICES))
                       && (32'(item_target_ff) < 32'(MAX_VERTICES));
   assign start_ok      = (32'(item_start_ff) < 32'(active_count));
   assign start_idx     = IDX_W'(item_start_ff);

   assign edge_present  = edge_rdata_ff[WGT_W];
   assign edge_weight   = edge_rdata_ff[WGT_W-1:0];
   assign dist_v        = dist_rdata_ff[DIST_W-1:0];
   assign pred_v        = dist_rdata_ff[DIST_DW-1:DIST_W];

   // Candidate distance, saturated to the 24-bit signed range.
   always_comb begin
      sum_w = {du_ff[DIST_W-1], du_ff}
            + {{(DIST_W + 1 - WGT_W){edge_weight[WGT_W-1]}}, edge_weight};
      if (sum_w[DIST_W] != sum_w[DIST_W-1]) begin
         cand = sum_w[DIST_W] ? DIST_MIN : DIST_MAX;
      end else begin
         cand = sum_w[DIST_W-1:0];
      end
   end

   assign relax_update = cmd.relax_wr && edge_present
                      && (32'(cmd_col) != 32'(item_start_ff))
                      && (!reached_ff[cmd_col] || (cand < dist_v));
   assign edge_update  = cmd.edge_wr && item_in_range
                      && (!edge_present || (item_weight_ff < edge_weight));

   // Port steering for the two stores.
   always_comb begin
      edge_we    = cmd.mem_clear || edge_update;
      edge_waddr = cmd.mem_clear ? {cmd_row, cmd_col} : item_addr;
      edge_wdata = cmd.mem_clear ? '0 : {1'b1, item_weight_ff};
      edge_re    = cmd.edge_rd || cmd.relax_rd;
      edge_raddr = cmd.edge_rd ? item_addr : {cmd_row, cmd_col};

      dist_we    = (cmd.run_init && start_ok) || relax_update;
      dist_waddr = cmd.run_init ? start_idx : cmd_col;
      dist_wdata = cmd.run_init ? '0 : {cmd_row, cand};
      dist_re    = cmd.dist_rd_row || cmd.relax_rd || cmd.out_rd;
      dist_raddr = cmd.dist_rd_row ? cmd_row : cmd_col;
   end

   always_ff @(posedge clock) begin
      if (edge_we) begin
         edge_mem[edge_waddr] <= edge_wdata;
      end
      if (edge_re) begin
         edge_rdata_ff <= edge_mem[edge_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[dist_waddr] <= dist_wdata;
      end
      if (dist_re) begin
         dist_rdata_ff <= dist_mem[dist_raddr];
      end
   end

   // Item fields and the running distance of the current origin row.
   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         item_source_ff <= req_edge_source;
         item_target_ff <= req_edge_target;
         item_weight_ff <= req_edge_weight;
         item_start_ff  <= req_start_vertex;
      end
      if (cmd.du_load) begin
         du_ff <= dist_v;
      end else if (relax_update && (cmd_col == cmd_row)) begin
         // A self loop that improves the origin changes the rest of its row.
         du_ff <= cand;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reached_ff <= '0;
         pvalid_ff  <= '0;
      end else if (cmd.run_init) begin
         reached_ff <= start_ok ? (MAX_VERTICES'(1) << start_idx) : '0;
         pvalid_ff  <= '0;
      end else if (relax_update) begin
         reached_ff[cmd_col] <= 1'b1;
         pvalid_ff[cmd_col]  <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.out_load) begin
         rsp_vertex_ff      <= VTX_W'(cmd_col);
         rsp_reachable_ff   <= reached_ff[cmd_col];
         rsp_distance_ff    <= reached_ff[cmd_col] ? dist_v : '0;
         rsp_has_pred_ff    <= pvalid_ff[cmd_col];
         rsp_predecessor_ff <= pvalid_ff[cmd_col] ? VTX_W'(pred_v) : '0;
         rsp_last_ff        <= cmd.out_last;
      end
   end

   assign status.row_reached = reached_ff[cmd_row];
   assign status.rsp_busy    = rsp_valid_ff && !rsp_ready;

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_vertex          = rsp_vertex_ff;
   assign rsp_distance        = rsp_distance_ff;
   assign rsp_reachable       = rsp_reachable_ff;
   assign rsp_predecessor     = rsp_predecessor_ff;
   assign rsp_has_predecessor = rsp_has_pred_ff;
   assign rsp_last            = rsp_last_ff;

   // A pending result is never overwritten.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> !(rsp_valid_ff && !rsp_ready))
      else $error("result register loaded while an item was still pending");

   // Every relaxation evaluates data read in the previous cycle.
   a_relax_order: assert property (@(posedge clock) disable iff (reset)
      cmd.relax_wr |-> $past(cmd.relax_rd))
      else $error("relaxation without a preceding store read");

   // An improved vertex is always reached.
   a_pred_reached: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_has_pred_ff |-> rsp_reachable_ff)
      else $error("result has a predecessor but is not reachable");

endmodule

`default_nettype wire

// ===== src/single_source_shortest_path_core.sv =====
// Single-source shortest path core (Bellman-Ford) over a dense directed graph of up
// to MAX_VERTICES vertices. An add item reads the edge store entry, then writes it, and
// keeps the smaller weight of parallel edges; a clear item, and reset, sweep the edge
// store one entry a cycle, during which no item is accepted. A run item writes the start
// distance, then makes n-1 passes over the n origin rows: an unreached row is skipped, a
// reached row reads the origin distance, loads it, then reads and compare-and-writes each
// entry on the single-port edge and distance stores. The n results follow, each read from
// the distance store and then loaded into the output register, which holds one result and
// waits while the output stalls; the last one stays in the output register while
// the next item is taken. Uses sssp_pkg, sssp_ctrl and sssp_datapath.
`default_nettype none

module single_source_shortest_path_core #(
   parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   output logic                               req_ready,
   input  wire  [sssp_pkg::KIND_W-1:0]        req_kind,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_edge_source,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_edge_target,
   input  wire  signed [sssp_pkg::WGT_W-1:0]  req_edge_weight,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_start_vertex,
   output logic                               rsp_valid,
   input  wire                                rsp_ready,
   output logic [sssp_pkg::VTX_W-1:0]         rsp_vertex,
   output logic signed [sssp_pkg::DIST_W-1:0] rsp_distance,
   output logic                               rsp_reachable,
   output logic [sssp_pkg::VTX_W-1:0]         rsp_predecessor,
   output logic                               rsp_has_predecessor,
   output logic                               rsp_last,
   input  wire                                csr_write_enable,
   input  wire  [sssp_pkg::VC_W-1:0]          csr_write_data
);
   import sssp_pkg::*;

   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int CNT_W = $clog2(MAX_VERTICES + 1);

   dp_cmd_type        cmd;
   dp_status_type     status;
   logic [IDX_W-1:0]  cmd_row;
   logic [IDX_W-1:0]  cmd_col;
   logic [CNT_W-1:0]  active_count;

   sssp_ctrl #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_ctrl (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_kind         (req_kind),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd              (cmd),
      .status           (status),
      .cmd_row          (cmd_row),
      .cmd_col          (cmd_col),
      .active_count     (active_count)
   );

   sssp_datapath #(
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .cmd_row             (cmd_row),
      .cmd_col             (cmd_col),
      .active_count        (active_count),
      .req_edge_source     (req_edge_source),
      .req_edge_target     (req_edge_target),
      .req_edge_weight     (req_edge_weight),
      .req_start_vertex    (req_start_vertex),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_vertex          (rsp_vertex),
      .rsp_distance        (rsp_distance),
      .rsp_reachable       (rsp_reachable),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_last            (rsp_last)
   );

endmodule

`default_nettype wire

// ===== sim/sssp_path_checker.sv =====
// Scoreboard for the single-source shortest path core: mirrors the edge store and the
// vertex count from accepted items and register writes, predicts the vertex reports of
// every run and compares them with the result channel. Depends on sssp_pkg.
module sssp_path_checker #(
   parameter int MAX_VERTICES = sssp_pkg::MAX_VERTICES_DEF
) (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                req_valid,
   input  wire                                req_ready,
   input  wire  [sssp_pkg::KIND_W-1:0]        req_kind,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_edge_source,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_edge_target,
   input  wire  signed [sssp_pkg::WGT_W-1:0]  req_edge_weight,
   input  wire  [sssp_pkg::VTX_W-1:0]         req_start_vertex,
   input  wire                                rsp_valid,
   input  wire                                rsp_ready,
   input  wire  [sssp_pkg::VTX_W-1:0]         rsp_vertex,
   input  wire  signed [sssp_pkg::DIST_W-1:0] rsp_distance,
   input  wire                                rsp_reachable,
   input  wire  [sssp_pkg::VTX_W-1:0]         rsp_predecessor,
   input  wire                                rsp_has_predecessor,
   input  wire                                rsp_last,
   input  wire                                csr_write_enable,
   input  wire  [sssp_pkg::VC_W-1:0]          csr_write_data,
   output int                                 outstanding,
   output int                                 error_count
);
   import sssp_pkg::*;

   typedef struct packed {
      logic [VTX_W-1:0] vertex;
      dist_type         distance;
      logic             reachable;
      logic [VTX_W-1:0] predecessor;
      logic             has_predecessor;
      logic             last;
   } vertex_report_type;

   weight_type        stored_weight  [MAX_VERTICES*MAX_VERTICES];
   logic              stored_present [MAX_VERTICES*MAX_VERTICES];
   logic [VC_W-1:0]   vertex_count;
   vertex_report_type expected_reports [$];
   int                mismatches = 0;

   // Parallel edges keep the smallest weight.
   task automatic load_edge(input logic [VTX_W-1:0] from_v, input logic [VTX_W-1:0] to_v,
                            input weight_type w);
      int k;
      if (int'(from_v) < MAX_VERTICES && int'(to_v) < MAX_VERTICES) begin
         k = int'(from_v) * MAX_VERTICES + int'(to_v);
         if (!stored_present[k] || w < stored_weight[k]) begin
            stored_weight[k]  = w;
            stored_present[k] = 1'b1;
         end
      end
   endtask

   task automatic solve_from(input logic [VTX_W-1:0] origin);
      int                       n;
      int                       k;
      dist_type                 path_len  [MAX_VERTICES];
      logic                     hit       [MAX_VERTICES];
      logic [VTX_W-1:0]         via       [MAX_VERTICES];
      logic                     via_valid [MAX_VERTICES];
      logic signed [DIST_W+1:0] sum;
      dist_type                 cand;
      vertex_report_type        rep;
      if (vertex_count == 0)
         n = 1;
      else if (int'(vertex_count) > MAX_VERTICES)
         n = MAX_VERTICES;
      else
         n = int'(vertex_count);
      for (int v = 0; v < MAX_VERTICES; v++) begin
         path_len[v]  = '0;
         hit[v]       = 1'b0;
         via[v]       = '0;
         via_valid[v] = 1'b0;
      end
      if (int'(origin) < n)
         hit[origin] = 1'b1;
      for (int pass = 0; pass + 1 < n; pass++) begin
         for (int u = 0; u < n; u++) begin
            if (!hit[u])
               continue;
            for (int v = 0; v < n; v++) begin
               k = u * MAX_VERTICES + v;
               if (!stored_present[k] || v == int'(origin))
                  continue;
               // The sum saturates to the distance range before the compare.
               sum = path_len[u] + stored_weight[k];
               if (sum > DIST_MAX)
                  cand = DIST_MAX;
               else if (sum < DIST_MIN)
                  cand = DIST_MIN;
               else
                  cand = sum[DIST_W-1:0];
               if (!hit[v] || cand < path_len[v]) begin
                  path_len[v]  = cand;
                  hit[v]       = 1'b1;
                  via[v]       = VTX_W'(u);
                  via_valid[v] = 1'b1;
               end
            end
         end
      end
      for (int v = 0; v < n; v++) begin
         rep.vertex          = VTX_W'(v);
         rep.distance        = hit[v] ? path_len[v] : '0;
         rep.reachable       = hit[v];
         rep.predecessor     = via_valid[v] ? via[v] : '0;
         rep.has_predecessor = via_valid[v];
         rep.last            = (v == n - 1);
         expected_reports.push_back(rep);
      end
   endtask

   always @(posedge clock) begin : observe
      vertex_report_type got;
      vertex_report_type want;
      if (reset) begin
         vertex_count = VERTEX_COUNT_RESET;
         foreach (stored_present[k]) stored_present[k] = 1'b0;
         expected_reports.delete();
      end else begin
         if (csr_write_enable)
            vertex_count = csr_write_data;
         if (req_valid && req_ready) begin
            case (req_kind)
               KIND_ADD:   load_edge(req_edge_source, req_edge_target, req_edge_weight);
               KIND_RUN:   solve_from(req_start_vertex);
               KIND_CLEAR: foreach (stored_present[k]) stored_present[k] = 1'b0;
               default:    ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            got = {rsp_vertex, rsp_distance, rsp_reachable, rsp_predecessor,
                   rsp_has_predecessor, rsp_last};
            if (expected_reports.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected report: v=%0d dist=%0d reach=%0b pred=%0d/%0b last=%0b",
                           got.vertex, $signed(got.distance), got.reachable,
                           got.predecessor, got.has_predecessor, got.last);
            end else begin
               want = expected_reports.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("expected v=%0d dist=%0d reach=%0b pred=%0d/%0b last=%0b",
                              want.vertex, $signed(want.distance), want.reachable,
                              want.predecessor, want.has_predecessor, want.last);
                     $display("  actual v=%0d dist=%0d reach=%0b pred=%0d/%0b last=%0b",
                              got.vertex, $signed(got.distance), got.reachable,
                              got.predecessor, got.has_predecessor, got.last);
                  end
               end
            end
         end
      end
      outstanding <= expected_reports.size();
      error_count <= mismatches;
   end

endmodule

// ===== sim/single_source_shortest_path_core_test.sv =====
// Testbench top for the single-source shortest path core: drives graph, clear, run and unused
// items with random gaps and output stalls and gives the verdict from the failure count
// of sssp_path_checker. Depends on sssp_pkg, the core and the checker.
module single_source_shortest_path_core_test;
   import sssp_pkg::*;

   localparam int ITEM_TARGET   = 410;
   localparam int SETTLE_CYCLES = 300;
   localparam int STALL_LIMIT   = 40000;
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

   logic                clock            = 1'b0;
   logic                reset            = 1'b1;
   logic                req_valid        = 1'b0;
   logic                req_ready;
   logic [KIND_W-1:0]   req_kind         = KIND_ADD;
   logic [VTX_W-1:0]    req_edge_source  = '0;
   logic [VTX_W-1:0]    req_edge_target  = '0;
   weight_type          req_edge_weight  = '0;
   logic [VTX_W-1:0]    req_start_vertex = '0;
   logic                rsp_valid;
   logic                rsp_ready        = 1'b0;
   logic [VTX_W-1:0]    rsp_vertex;
   dist_type            rsp_distance;
   logic                rsp_reachable;
   logic [VTX_W-1:0]    rsp_predecessor;
   logic                rsp_has_predecessor;
   logic                rsp_last;
   logic                csr_write_enable = 1'b0;
   logic [VC_W-1:0]     csr_write_data   = '0;
   int                  outstanding;
   int                  error_count;
   logic                steady           = 1'b0;
   int                  items_sent       = 0;
   int                  rsp_hold         = 0;

   always #1 clock = ~clock;

   single_source_shortest_path_core u_top (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_edge_source     (req_edge_source),
      .req_edge_target     (req_edge_target),
      .req_edge_weight     (req_edge_weight),
      .req_start_vertex    (req_start_vertex),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_vertex          (rsp_vertex),
      .rsp_distance        (rsp_distance),
      .rsp_reachable       (rsp_reachable),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data)
   );

   sssp_path_checker u_path_checker (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_kind            (req_kind),
      .req_edge_source     (req_edge_source),
      .req_edge_target     (req_edge_target),
      .req_edge_weight     (req_edge_weight),
      .req_start_vertex    (req_start_vertex),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_vertex          (rsp_vertex),
      .rsp_distance        (rsp_distance),
      .rsp_reachable       (rsp_reachable),
      .rsp_predecessor     (rsp_predecessor),
      .rsp_has_predecessor (rsp_has_predecessor),
      .rsp_last            (rsp_last),
      .csr_write_enable    (csr_write_enable),
      .csr_write_data      (csr_write_data),
      .outstanding         (outstanding),
      .error_count         (error_count)
   );

   // After each accepted result the receiver stalls for a freshly drawn number of cycles.
   always @(posedge clock) begin : result_stall
      int drawn;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= 0;
      end else if (rsp_valid && rsp_ready) begin
         drawn = steady ? 0 : $urandom_range(0, 9);
         rsp_hold  <= drawn;
         rsp_ready <= (drawn == 0);
      end else if (rsp_hold > 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet = 0;
         else
            quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // Called at a clock edge; returns at the edge where the item is accepted, valid still high.
   task automatic issue(input logic [KIND_W-1:0] kind, input logic [VTX_W-1:0] from_v,
                        input logic [VTX_W-1:0] to_v, input weight_type w,
                        input logic [VTX_W-1:0] origin);
      int gap;
      gap = steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_kind         <= kind;
      req_edge_source  <= from_v;
      req_edge_target  <= to_v;
      req_edge_weight  <= w;
      req_start_vertex <= origin;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (kind != KIND_UNUSED)
         items_sent++;
   endtask

   task automatic add_edge(input logic [VTX_W-1:0] from_v, input logic [VTX_W-1:0] to_v,
                           input weight_type w);
      issue(KIND_ADD, from_v, to_v, w, VTX_W'($urandom_range(0, 15)));
   endtask

   task automatic run_from(input logic [VTX_W-1:0] origin);
      issue(KIND_RUN, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)),
            weight_type'($urandom_range(0, 65535)), origin);
   endtask

   task automatic issue_filler(input logic [KIND_W-1:0] kind);
      issue(kind, VTX_W'($urandom_range(0, 15)), VTX_W'($urandom_range(0, 15)),
            weight_type'($urandom_range(0, 65535)), VTX_W'($urandom_range(0, 15)));
   endtask

   task automatic write_vertex_count(input logic [VC_W-1:0] value);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   // Holds off the sender until every report has arrived, then lets a clear sweep finish.
   task automatic drain_and_settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [VTX_W-1:0] pick_vertex(input int n);
      if ($urandom_range(0, 6) == 0)
         return VTX_W'($urandom_range(0, 15));
      return VTX_W'($urandom_range(0, n - 1));
   endfunction

   function automatic weight_type pick_weight(input int style);
      case (style)
         0: return weight_type'($urandom_range(0, 50));
         1: return weight_type'(int'($urandom_range(0, 60)) - 10);
         2: return weight_type'($urandom_range(0, 65535));
         default: begin
            case ($urandom_range(0, 4))
               0: return weight_type'(-32768);
               1: return weight_type'(32767);
               2: return weight_type'(-1);
               3: return weight_type'(0);
               default: return weight_type'(1);
            endcase
         end
      endcase
   endfunction

   initial begin : stimulus
      int roll;
      int vc_now;
      int eff_n;
      int edges_left;
      int runs_left;
      int style;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Four vertices: parallel edges, extreme weights, self loop, edge into the start.
      write_vertex_count(5'd4);
      add_edge(4'd0, 4'd1, weight_type'(32767));
      add_edge(4'd0, 4'd1, weight_type'(5));
      add_edge(4'd0, 4'd1, weight_type'(9));
      add_edge(4'd1, 4'd2, weight_type'(-32768));
      add_edge(4'd2, 4'd3, weight_type'(-1));
      add_edge(4'd3, 4'd3, weight_type'(-1));
      add_edge(4'd15, 4'd15, weight_type'(7));
      add_edge(4'd3, 4'd0, weight_type'(100));
      issue_filler(KIND_UNUSED);
      run_from(4'd0);
      run_from(4'd2);
      run_from(4'd7);
      run_from(4'd3);
      drain_and_settle();

      // Full size: the stored edge beyond the old count now takes part.
      write_vertex_count(5'd16);
      run_from(4'd0);
      add_edge(4'd0, 4'd15, weight_type'(0));
      run_from(4'd0);
      issue_filler(KIND_CLEAR);
      run_from(4'd0);
      drain_and_settle();

      write_vertex_count(5'd1);
      add_edge(4'd0, 4'd0, weight_type'(-5));
      run_from(4'd0);
      drain_and_settle();
      write_vertex_count(5'd0);
      run_from(4'd0);
      run_from(4'd1);
      drain_and_settle();
      write_vertex_count(5'd31);
      add_edge(4'd0, 4'd15, weight_type'(-3));
      run_from(4'd0);
      drain_and_settle();

      // A heavily negative ring with self loops drives distances into saturation.
      write_vertex_count(5'd16);
      issue_filler(KIND_CLEAR);
      add_edge(4'd0, 4'd1, pick_weight(1));
      for (int v = 1; v < 16; v++) begin
         add_edge(VTX_W'(v), VTX_W'(v), weight_type'(-int'($urandom_range(28000, 32768))));
         add_edge(VTX_W'(v), (v == 15) ? 4'd1 : VTX_W'(v + 1),
                  weight_type'(-int'($urandom_range(28000, 32768))));
      end
      run_from(4'd0);
      run_from(4'd5);
      drain_and_settle();
      vc_now = 16;

      while (items_sent < ITEM_TARGET) begin
         if ($urandom_range(0, 2) != 0) begin
            roll = $urandom_range(0, 19);
            case (roll)
               0:       vc_now = 0;
               1:       vc_now = 1;
               2:       vc_now = 16;
               3:       vc_now = $urandom_range(17, 31);
               4, 5:    vc_now = $urandom_range(7, 15);
               default: vc_now = $urandom_range(2, 6);
            endcase
            write_vertex_count(VC_W'(vc_now));
         end
         eff_n      = (vc_now == 0) ? 1 : (vc_now > 16) ? 16 : vc_now;
         edges_left = $urandom_range(0, 3 * eff_n);
         runs_left  = $urandom_range(1, 3);
         style      = $urandom_range(0, 3);
         steady    <= ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 1)
            issue_filler(KIND_CLEAR);
         while (edges_left + runs_left > 0) begin
            roll = $urandom_range(0, 29);
            if (roll == 0)
               issue_filler(KIND_UNUSED);
            else if (roll == 1)
               issue_filler(KIND_CLEAR);
            if ($urandom_range(1, edges_left + runs_left) <= runs_left) begin
               run_from(pick_vertex(eff_n));
               runs_left--;
            end else begin
               add_edge(pick_vertex(eff_n), pick_vertex(eff_n), pick_weight(style));
               edges_left--;
            end
         end
         drain_and_settle();
      end

      if (error_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

// ===== sim.f =====
src/sssp_pkg.sv
src/sssp_ctrl.sv
src/sssp_datapath.sv
src/single_source_shortest_path_core.sv
sim/sssp_path_checker.sv
sim/single_source_shortest_path_core_test.sv
